### sv/nbc_pkg.sv
package nbc_pkg;

  // Field widths of the item, result and configuration words
  localparam int unsigned IDX_W    = 20;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned NODE_W   = 21;
  localparam int unsigned TOTAL_W  = 21;
  // Wide enough to compare against any node count limit (up to 2^24)
  localparam int unsigned CMP_W    = 25;

  localparam int unsigned MAX_BLOCK_COLUMNS_DEF = 1024;
  localparam int unsigned MAX_NODES_DEF         = 1048576;

  // Divider retires this many quotient bits per cycle
  localparam int unsigned RADIX_BITS = 2;
  localparam int unsigned DIV_STEPS  = IDX_W / RADIX_BITS;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b1;

  localparam logic MODE_EDGE   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] column_index;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] nonzero_blocks;
    logic               range_error;
    logic               order_error;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] row_quot;
    logic [IDX_W-1:0] col_quot;
  } div_rsp_t;

endpackage

### sv/nbc_divider.sv
module nbc_divider (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  nbc_pkg::div_req_t req,
  output nbc_pkg::div_rsp_t rsp
);
  import nbc_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step_cnt;
  logic [SIZE_W-1:0] divisor;
  logic [SIZE_W-1:0] rem      [2];
  logic [IDX_W-1:0]  quot     [2];
  logic [SIZE_W-1:0] rem_next [2];
  logic [IDX_W-1:0]  quot_next[2];

  // Restoring division, two lanes (row, column) sharing the divisor
  always_comb begin
    logic [SIZE_W-1:0] r;
    logic [IDX_W-1:0]  q;
    logic [SIZE_W:0]   sh;
    for (int l = 0; l < 2; l++) begin
      r = rem[l];
      q = quot[l];
      for (int k = 0; k < RADIX_BITS; k++) begin
        sh = {r, q[IDX_W-1]};
        q  = {q[IDX_W-2:0], 1'b0};
        if (sh >= {1'b0, divisor}) begin
          sh   = sh - {1'b0, divisor};
          q[0] = 1'b1;
        end
        r = sh[SIZE_W-1:0];
      end
      rem_next[l]  = r;
      quot_next[l] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      step_cnt <= STEP_W'(DIV_STEPS - 1);
    end else if (busy) begin
      if (step_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step_cnt <= step_cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= req.divisor;
      rem[0]  <= '0;
      rem[1]  <= '0;
      quot[0] <= req.row;
      quot[1] <= req.col;
    end else if (busy) begin
      rem[0]  <= rem_next[0];
      rem[1]  <= rem_next[1];
      quot[0] <= quot_next[0];
      quot[1] <= quot_next[1];
    end
  end

  assign rsp.done     = done;
  assign rsp.row_quot = quot[0];
  assign rsp.col_quot = quot[1];

endmodule

### sv/nonzero_block_counter.sv
// Nonzero block counter for block-sparse row storage. Edge items (row, column) with rows in
// nondecreasing order are mapped to (row / block_size, column / block_size); a tag memory
// with one entry per block column holds the block row that last marked it, so each block
// counts once. A finish item returns the total and two error flags and starts a new matrix.
// Timing: an edge item's time is dominated by the two-lane divider that retires two quotient
// bits per cycle, followed by a tag read and a tag write; an item with an index out of range
// ends at the range check. After reset and after every finish item the tag memory is
// cleared one entry per cycle, during which no item is taken; configuration writes are taken
// at any time. The result sits in an output register, so edges of the next matrix flow while
// it waits.
module nonzero_block_counter #(
  parameter int unsigned MAX_BLOCK_COLUMNS = nbc_pkg::MAX_BLOCK_COLUMNS_DEF,
  parameter int unsigned MAX_NODES         = nbc_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  nbc_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output nbc_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nbc_pkg::NODE_W-1:0]      cfg_data
);
  import nbc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCK_COLUMNS);

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_CHECK    = 7'b0000100,
    S_DIVIDE   = 7'b0001000,
    S_TAG_READ = 7'b0010000,
    S_TAG_CMP  = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] brow;
  } tag_t;

  state_t             state, state_next;
  item_t              item_q;
  logic [SIZE_W-1:0]  block_size;
  logic [NODE_W-1:0]  node_count;
  logic [IDX_W-1:0]   previous_row;
  logic [TOTAL_W-1:0] block_total;
  logic               range_flag;
  logic               order_flag;
  logic [IDX_W-1:0]   brow;
  logic [IDX_W-1:0]   bcol;
  logic [AW-1:0]      clr_addr;

  tag_t               tag_mem [MAX_BLOCK_COLUMNS];
  tag_t               tag_q;
  tag_t               tag_wdata;
  logic [AW-1:0]      tag_waddr;
  logic               tag_we;
  logic               tag_re;

  logic [SIZE_W-1:0]  bs_eff;
  logic [CMP_W-1:0]   node_eff;
  logic               index_oor;
  logic               cap_fail;
  logic               row_back;
  logic               tag_hit;
  logic               clr_last;
  logic               out_free;
  logic               div_start;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign bs_eff   = (block_size == '0) ? SIZE_W'(1) : block_size;
  assign node_eff = ({{(CMP_W-NODE_W){1'b0}}, node_count} > CMP_W'(MAX_NODES))
                    ? CMP_W'(MAX_NODES) : {{(CMP_W-NODE_W){1'b0}}, node_count};

  assign index_oor = ({{(CMP_W-IDX_W){1'b0}}, item_q.row_index} >= node_eff) ||
                     ({{(CMP_W-IDX_W){1'b0}}, item_q.column_index} >= node_eff);
  assign cap_fail  = ({1'b0, brow} >= (IDX_W+1)'(MAX_BLOCK_COLUMNS)) ||
                     ({1'b0, bcol} >= (IDX_W+1)'(MAX_BLOCK_COLUMNS));
  assign row_back  = item_q.row_index < previous_row;
  assign tag_hit   = tag_q.valid && (tag_q.brow == brow[AW-1:0]);
  assign clr_last  = clr_addr == AW'(MAX_BLOCK_COLUMNS - 1);
  assign out_free  = !result_valid || result_ready;

  assign item_ready = state == S_IDLE;
  assign cfg_ready  = 1'b1;

  assign div_start       = (state == S_CHECK) && !index_oor;
  assign div_req.row     = item_q.row_index;
  assign div_req.col     = item_q.column_index;
  assign div_req.divisor = bs_eff;

  nbc_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (item_valid) state_next = (item.mode == MODE_FINISH) ? S_EMIT : S_CHECK;
      end
      S_CHECK:    state_next = index_oor ? S_IDLE : S_DIVIDE;
      S_DIVIDE:   if (div_rsp.done) state_next = S_TAG_READ;
      S_TAG_READ: state_next = (cap_fail || row_back) ? S_IDLE : S_TAG_CMP;
      S_TAG_CMP:  state_next = S_IDLE;
      S_EMIT:     if (out_free) state_next = S_CLEAR;
      default:    state_next = S_CLEAR;
    endcase
  end

  // Tag memory: clearing sweep or write back of a newly marked block
  assign tag_re    = (state == S_TAG_READ) && !cap_fail && !row_back;
  assign tag_we    = (state == S_CLEAR) || ((state == S_TAG_CMP) && !tag_hit);
  assign tag_waddr = (state == S_CLEAR) ? clr_addr : bcol[AW-1:0];
  always_comb begin
    tag_wdata.valid = state != S_CLEAR;
    tag_wdata.brow  = (state == S_CLEAR) ? '0 : brow[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (tag_re) tag_q <= tag_mem[bcol[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      block_size   <= SIZE_W'(1);
      node_count   <= NODE_W'(1048576);
      previous_row <= '0;
      block_total  <= '0;
      range_flag   <= 1'b0;
      order_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_BLOCK_SIZE: block_size <= cfg_data[SIZE_W-1:0];
          REG_NODE_COUNT: node_count <= cfg_data;
          default: ;
        endcase
      end
      if ((state == S_EMIT) && out_free) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        S_CHECK: if (index_oor) range_flag <= 1'b1;
        S_TAG_READ: begin
          if (cap_fail) range_flag <= 1'b1;
          else if (row_back) order_flag <= 1'b1;
          else previous_row <= item_q.row_index;
        end
        S_TAG_CMP: begin
          // count a block the first time its column sees this block row
          if (!tag_hit && (block_total != {TOTAL_W{1'b1}})) block_total <= block_total + 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            previous_row <= '0;
            block_total  <= '0;
            range_flag   <= 1'b0;
            order_flag   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_q <= item;
    if ((state == S_DIVIDE) && div_rsp.done) begin
      brow <= div_rsp.row_quot;
      bcol <= div_rsp.col_quot;
    end
    if ((state == S_EMIT) && out_free) begin
      result.nonzero_blocks <= block_total;
      result.range_error    <= range_flag;
      result.order_error    <= order_flag;
    end
  end

endmodule
